[design/bcc_pkg.sv]
package bcc_pkg;

	localparam int unsigned StampW = 32;
	localparam int unsigned MsW    = 16;

	localparam logic [MsW-1:0] LockoutReset    = 16'd350;
	localparam logic [MsW-1:0] DoubleWinReset  = 16'd600;
	localparam logic [MsW-1:0] LongPressReset  = 16'd5000;

	// configuration register indexes
	localparam logic [1:0] RegLockout   = 2'd0;
	localparam logic [1:0] RegDoubleWin = 2'd1;
	localparam logic [1:0] RegLongPress = 2'd2;

	// item kinds carried on tuser
	localparam logic OpEdge = 1'b0;
	localparam logic OpPoll = 1'b1;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_PREV   = 3'd1,
		EV_NEXT   = 3'd2,
		EV_SELECT = 3'd3,
		EV_DOUBLE = 3'd4,
		EV_LONG   = 3'd5
	} event_t;

	typedef struct packed {
		logic [MsW-1:0] lockout_ms;
		logic [MsW-1:0] double_window_ms;
		logic [MsW-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic              op;
		logic [2:0]        pin_mask;
		logic [StampW-1:0] now_ms;
		logic              select_held;
	} item_t;

endpackage

[design/bcc_cfg.sv]
module bcc_cfg (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_en,
	input  logic [1:0]   wr_index,
	input  logic [15:0]  wr_data,
	output bcc_pkg::cfg_t cfg
);
	import bcc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ms       <= LockoutReset;
			cfg_q.double_window_ms <= DoubleWinReset;
			cfg_q.long_press_ms    <= LongPressReset;
		end else if (wr_en) begin
			case (wr_index)
				RegLockout:   cfg_q.lockout_ms       <= wr_data;
				RegDoubleWin: cfg_q.double_window_ms <= wr_data;
				RegLongPress: cfg_q.long_press_ms    <= wr_data;
				default:      ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/bcc_classify.sv]
module bcc_classify (
	input  logic           clk,
	input  logic           arst_n,
	input  bcc_pkg::cfg_t  cfg,
	input  logic           fire,
	input  bcc_pkg::item_t item,
	output bcc_pkg::event_t result_code
);
	import bcc_pkg::*;

	logic [StampW-1:0] prev_stamp_q, next_stamp_q, select_stamp_q;
	event_t            pending_q;

	logic [StampW-1:0] age_prev, age_next, age_sel;
	logic [StampW-1:0] lockout, dbl_win, long_lim;
	logic              ok_prev, ok_next, ok_sel, sel_set, is_long;

	assign lockout  = {{(StampW-MsW){1'b0}}, cfg.lockout_ms};
	assign dbl_win  = {{(StampW-MsW){1'b0}}, cfg.double_window_ms};
	assign long_lim = {{(StampW-MsW){1'b0}}, cfg.long_press_ms};

	// wrapping ages
	assign age_prev = item.now_ms - prev_stamp_q;
	assign age_next = item.now_ms - next_stamp_q;
	assign age_sel  = item.now_ms - select_stamp_q;

	assign ok_prev = age_prev >= lockout;
	assign ok_next = age_next >= lockout;
	assign ok_sel  = age_sel >= lockout;
	assign sel_set = select_stamp_q != '0;
	assign is_long = item.select_held && sel_set && (age_sel > long_lim);

	assign result_code = is_long ? EV_LONG : pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_stamp_q   <= '0;
			next_stamp_q   <= '0;
			select_stamp_q <= '0;
			pending_q      <= EV_NONE;
		end else if (fire) begin
			if (item.op == OpPoll) begin
				if (is_long) begin
					select_stamp_q <= '0;
				end else begin
					pending_q <= EV_NONE;
				end
			end else if (item.pin_mask[0]) begin
				if (ok_prev) begin
					prev_stamp_q <= item.now_ms;
					pending_q    <= EV_PREV;
				end
			end else if (item.pin_mask[1]) begin
				if (ok_next) begin
					next_stamp_q <= item.now_ms;
					pending_q    <= EV_NEXT;
				end
			end else if (item.pin_mask[2] && ok_sel) begin
				if (sel_set && (age_sel < dbl_win)) begin
					pending_q      <= EV_DOUBLE;
					select_stamp_q <= '0;
				end else begin
					pending_q      <= EV_SELECT;
					select_stamp_q <= item.now_ms;
				end
			end
		end
	end

endmodule

[design/button_click_classifier.sv]
// Button click classifier: turns press edges of the prev, next and select
// buttons into click events and hands them out on polls. An edge item (tuser 0)
// updates the per-button timestamps and the pending event and gives no result;
// a poll item (tuser 1) gives exactly one result, a long press or the pending
// event. Each item goes from acceptance to result through the input register,
// then one pass of subtract-and-compare logic into the result register, and
// one item is accepted every cycle; only a poll that finds the result register
// still full and not taken holds the input. Configuration writes are taken on
// any cycle but should only be issued while no item is in flight.
module button_click_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // pin_mask[2:0], now_ms[34:3], select_held[35], zero pad
	input  logic        s_tuser,  // op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // event_code[2:0], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import bcc_pkg::*;

	cfg_t   cfg;
	item_t  item_s1;
	logic   valid_s1;
	logic   advance;
	event_t result_code;
	event_t code_q;
	logic   out_valid_q;

	assign cfg_ready = 1'b1;

	bcc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// edge items never wait; a poll waits for room in the result register
	assign advance  = valid_s1 &&
		!((item_s1.op == OpPoll) && out_valid_q && !m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op          <= s_tuser;
			item_s1.pin_mask    <= s_tdata[2:0];
			item_s1.now_ms      <= s_tdata[34:3];
			item_s1.select_held <= s_tdata[35];
		end
	end

	bcc_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.fire        (advance),
		.item        (item_s1),
		.result_code (result_code)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			code_q      <= EV_NONE;
		end else if (advance && (item_s1.op == OpPoll)) begin
			out_valid_q <= 1'b1;
			code_q      <= result_code;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, code_q};

`ifndef SYNTHESIS
	a_poll_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (item_s1.op == OpPoll)) |=> m_tvalid)
		else $error("poll item produced no result");

	a_poll_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(advance && (item_s1.op == OpPoll)))
		else $error("pending result overwritten");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (code_q <= EV_LONG))
		else $error("event code out of range");
`endif

endmodule
